>>> rtl/lcg48_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the 48-bit congruential random source.
// No dependencies; used by lcg48_adv, lcg48_div and lcg48_random_source.
package lcg48_pkg;

  localparam int unsigned SEED_W = 48;
  localparam int unsigned MULT_W = 35;
  localparam int unsigned MOD_W  = 31;
  localparam int unsigned DVD_W  = 49;
  localparam int unsigned CNT_W  = 6;

  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_INC  = 48'hB;

  localparam logic [DVD_W-1:0] FRAC_D    = 49'hFFFFFF;
  localparam logic [MOD_W-1:0] FRAC_DIV2 = 31'd33554430;

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_MOD  = 2'd1;
  localparam logic [1:0] MODE_FRAC = 2'd2;

  localparam logic [SEED_W-1:0] SEED_RST = 48'hB;

endpackage

>>> rtl/lcg48_adv.sv
`timescale 1ns / 1ps
// Bit-serial seed advance: seed * multiplier + increment mod 2^48.
// One multiplier bit per cycle; depends on lcg48_pkg.
module lcg48_adv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lcg48_pkg::SEED_W-1:0] seed_i,
  output logic                         done_o,
  output logic [lcg48_pkg::SEED_W-1:0] seed_o
);
  import lcg48_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SEED_W-1:0] acc_q, acc_d;
  logic [SEED_W-1:0] mcand_q;

  assign acc_d = LCG_MULT[cnt_q] ? acc_q + mcand_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MULT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= LCG_INC;
      mcand_q <= seed_i;
    end else if (busy_q) begin
      acc_q   <= acc_d;
      mcand_q <= {mcand_q[SEED_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign seed_o = acc_q;

endmodule

>>> rtl/lcg48_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of a 49-bit dividend; depends on lcg48_pkg.
module lcg48_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lcg48_pkg::DVD_W-1:0] dividend_i,
  input  logic [lcg48_pkg::MOD_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [lcg48_pkg::DVD_W-1:0] quot_o,
  output logic [lcg48_pkg::MOD_W-1:0] rem_o
);
  import lcg48_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W-1:0] dsr_q;
  logic [MOD_W:0]   part;
  logic [MOD_W:0]   diff;
  logic             ge;

  assign part = {rem_q, dvd_q[DVD_W-1]};
  assign ge   = part >= {1'b0, dsr_q};
  assign diff = part - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[MOD_W-1:0] : part[MOD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/lcg48_random_source.sv
`timescale 1ns / 1ps
// 48-bit linear congruential random source: sequencer, register port, output register.
// Depends on lcg48_pkg, lcg48_adv and lcg48_div.
//
// Usage: each request on the s_axis channel (tuser = mode, tdata = modulus) advances
// the seed and yields one result on m_axis (tdata = value, tuser = error flag).
// Mode 0 (and 3) returns the seed, mode 1 the seed modulo the modulus, mode 2 the
// low 24 bits as a Q1.24 fraction of 0xFFFFFF. A zero modulus in mode 1 returns 0
// with the error flag set.
// The serial multiplier takes one multiplier bit a cycle; mode 2 and mode 1 with a
// nonzero modulus then pass through the restoring divider (one quotient bit a cycle).
// The sequencer steps from idle through the advance state, the divide state when
// one is needed, and a finish state that fills the output register. One request is
// in flight at a time; the next one is taken once the sequencer is back in idle.
// Reset loads the seed with 0xB and start_seed with 0. Writing start_seed over the
// APB port (addresses 0 to 7) loads the seed with its successor; s_axis_tready
// stays low until that advance is done. A finished result waits in the output register
// while the next request runs; if the receiver still stalls, the sequencer holds.
module lcg48_random_source (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [30:0] modulus
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [47:0] value
  output logic        m_axis_tuser,  // [0] error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import lcg48_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADV  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_q;
  logic              cfg_pend_q;
  logic              is_cfg_q;
  logic [SEED_W-1:0] start_seed_q;
  logic [SEED_W-1:0] seed_q;
  logic [1:0]        mode_q;
  logic [MOD_W-1:0]  modulus_q;
  logic [SEED_W-1:0] val_q;
  logic              err_q;
  logic              out_valid_q;
  logic [SEED_W-1:0] out_data_q;
  logic              out_err_q;

  logic              in_acc;
  logic              out_acc;
  logic              cfg_wr;
  logic              adv_start;
  logic [SEED_W-1:0] adv_operand;
  logic              adv_done;
  logic [SEED_W-1:0] adv_seed;
  logic              need_div;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [MOD_W-1:0]  div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quot;
  logic [MOD_W-1:0]  div_rem;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && !paddr[3];
  assign prdata  = paddr[3] ? 64'd0 : {16'd0, start_seed_q};

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_pend_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid_q && m_axis_tready;

  assign adv_start   = (state_q == ST_IDLE) && (cfg_pend_q || s_axis_tvalid);
  assign adv_operand = cfg_pend_q ? start_seed_q : seed_q;

  assign need_div  = (mode_q == MODE_FRAC) || ((mode_q == MODE_MOD) && (modulus_q != '0));
  assign div_start = (state_q == ST_ADV) && adv_done && !is_cfg_q && need_div;
  assign div_dividend = (mode_q == MODE_FRAC)
                      ? ({adv_seed[23:0], 25'd0} + FRAC_D)
                      : {1'b0, adv_seed};
  assign div_divisor  = (mode_q == MODE_FRAC) ? FRAC_DIV2 : modulus_q;

  lcg48_adv u_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (adv_start),
    .seed_i  (adv_operand),
    .done_o  (adv_done),
    .seed_o  (adv_seed)
  );

  lcg48_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_pend_q   <= 1'b0;
      is_cfg_q     <= 1'b0;
      start_seed_q <= '0;
      seed_q       <= SEED_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_seed_q <= pwdata[SEED_W-1:0];
        cfg_pend_q   <= 1'b1;
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (adv_start) begin
            is_cfg_q <= cfg_pend_q;
            if (cfg_pend_q && !cfg_wr) begin
              cfg_pend_q <= 1'b0;
            end
            state_q <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (adv_done) begin
            seed_q <= adv_seed;
            if (is_cfg_q) begin
              state_q <= ST_IDLE;
            end else if (need_div) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= s_axis_tuser;
      modulus_q <= s_axis_tdata[MOD_W-1:0];
    end
    if ((state_q == ST_ADV) && adv_done) begin
      val_q <= ((mode_q == MODE_MOD) && (modulus_q == '0)) ? '0 : adv_seed;
      err_q <= (mode_q == MODE_MOD) && (modulus_q == '0);
    end
    if ((state_q == ST_DIV) && div_done) begin
      val_q <= (mode_q == MODE_FRAC) ? div_quot[SEED_W-1:0]
                                     : {{(SEED_W-MOD_W){1'b0}}, div_rem};
    end
    if ((state_q == ST_FIN) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= val_q;
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  a_acc_to_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_ADV)
    else $error("accepted request did not start an advance");

  a_adv_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_done |-> state_q == ST_ADV)
    else $error("advance finished outside its state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("division finished outside its state");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("error result carries a nonzero value");

endmodule

>>> tb/tb_lcg48_random_source.sv
`timescale 1ns / 1ps
// Testbench for lcg48_random_source: drives requests, stalls and seed writes and
// checks each result against its own model of the 48-bit seed sequence.
// Depends on lcg48_pkg and the lcg48_random_source RTL.
module tb_lcg48_random_source;
  import lcg48_pkg::*;

  localparam logic [1:0] MODE_UNUSED     = 2'd3;
  localparam logic [3:0] ADDR_START_SEED = 4'h0;
  localparam logic [3:0] ADDR_UNMAPPED   = 4'h8;
  localparam int         DRAIN_CYCLES    = 120;

  typedef struct packed {
    logic [47:0] value;
    logic        error;
  } lcg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [30:0] modulus
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [47:0] value
  logic        m_axis_tuser;   // [0] error
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  lcg_result_t pending_results[$];
  logic [47:0] seed_model;
  logic [47:0] start_seed_model;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_request = 0;
  int          stall_left = 0;

  lcg48_random_source dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [47:0] lcg_next(logic [47:0] s);
    logic [95:0] p;
    p = 96'(s) * 96'(LCG_MULT) + 96'(LCG_INC);
    return p[47:0];
  endfunction

  function automatic logic [47:0] lcg_prev(logic [47:0] s);
    logic [47:0] m;
    logic [47:0] inv;
    m = 48'(LCG_MULT);
    inv = m;
    repeat (5) inv = inv * (48'd2 - m * inv);
    return (s - LCG_INC) * inv;
  endfunction

  function automatic lcg_result_t predict_result(logic [47:0] seed, logic [1:0] mode,
                                                 logic [30:0] modulus);
    lcg_result_t r;
    logic [63:0] scaled;
    r.error = 1'b0;
    r.value = seed;
    if (mode == MODE_MOD) begin
      if (modulus == '0) begin
        r.value = '0;
        r.error = 1'b1;
      end else begin
        r.value = 48'(64'(seed) % 64'(modulus));
      end
    end else if (mode == MODE_FRAC) begin
      scaled = (64'(seed[23:0]) << 25) + 64'(FRAC_D);
      r.value = 48'(scaled / (64'(FRAC_D) * 64'd2));
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seed_model = lcg_next(seed_model);
      pending_results.push_back(predict_result(seed_model, s_axis_tuser, s_axis_tdata[30:0]));
    end
  end

  always @(posedge clk_i) begin
    lcg_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %h error %b", $time, m_axis_tdata,
                 m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [1:0] mode, logic [30:0] modulus);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, modulus};
    do @(posedge clk_i); while (!s_axis_tready);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic [3:0] addr, logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_start_seed();
    logic [63:0] rd;
    apb_access(1'b0, ADDR_START_SEED, '0, rd);
    if (rd[47:0] !== start_seed_model) begin
      $display("%0t: start_seed read expected %h actual %h", $time, start_seed_model,
               rd[47:0]);
      mismatch_count++;
    end
  endtask

  task automatic write_start_seed(logic [47:0] seed);
    logic [63:0] rd;
    apb_access(1'b1, ADDR_START_SEED, {16'b0, seed}, rd);
    start_seed_model = seed;
    seed_model = lcg_next(seed);
    check_start_seed();
  endtask

  task automatic random_request();
    logic [1:0]  mode;
    logic [30:0] modulus;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 30) mode = MODE_MOD;
    else if (pick < 60) mode = MODE_FRAC;
    else if (pick < 90) mode = MODE_RAW;
    else mode = MODE_UNUSED;
    case ($urandom_range(7))
      0: modulus = '0;
      1: modulus = 31'($urandom_range(1, 16));
      2: modulus = 31'd1 << $urandom_range(0, 30);
      3: modulus = '1;
      default: modulus = 31'($urandom);
    endcase
    send_request(mode, modulus);
  endtask

  task automatic test_register_port();
    logic [63:0] rd;
    check_start_seed();
    apb_access(1'b1, ADDR_UNMAPPED, {16'b0, 48'hFFFF_FFFF_FFFF}, rd);
    check_start_seed();
    send_request(MODE_RAW, '0);
    wait_drained();
    write_start_seed(48'({$urandom, $urandom}));
    send_request(MODE_RAW, '0);
    wait_drained();
  endtask

  task automatic test_directed_modes();
    send_request(MODE_RAW, '1);
    send_request(MODE_MOD, '0);
    send_request(MODE_MOD, 31'd1);
    send_request(MODE_MOD, 31'd2);
    send_request(MODE_MOD, '1);
    send_request(MODE_FRAC, '0);
    send_request(MODE_FRAC, '1);
    send_request(MODE_UNUSED, 31'h5555_5555);
    send_request(MODE_UNUSED, 31'h2AAA_AAAA);
    wait_drained();
  endtask

  task automatic test_seed_extremes();
    logic [47:0] targets[4];
    targets = '{48'hFFFF_FFFF_FFFF, 48'h0, 48'h1234_56FF_FFFF, 48'hFEDC_BA00_0000};
    foreach (targets[i]) begin
      write_start_seed(lcg_prev(lcg_prev(targets[i])));
      send_request(i < 2 ? MODE_RAW : MODE_FRAC, 31'h7FFF_FFFF);
      send_request(MODE_MOD, 31'h7FFF_FFFF);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1200;
    repeat (20) random_request();
    wait_drained();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count,
                                     logic [47:0] seed);
    write_start_seed(seed);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) random_request();
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_RAW;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= ADDR_START_SEED;
    pwdata        <= '0;
    start_seed_model = '0;
    seed_model = lcg_next('0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_register_port();
    test_directed_modes();
    test_seed_extremes();
    test_backpressure();
    test_random_traffic(16, 55, 530, 48'({$urandom, $urandom}));
    test_random_traffic(55, 16, 530, 48'hFFFF_FFFF_FFFF);
    test_random_traffic(0, 0, 530, 48'h0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/lcg48_pkg.sv
rtl/lcg48_adv.sv
rtl/lcg48_div.sv
rtl/lcg48_random_source.sv
tb/tb_lcg48_random_source.sv
